### design/pcpk_pkg.sv
`default_nettype none
package pcpk_pkg;
  localparam int unsigned MaxChannels = 8;
  localparam int unsigned PosW = $clog2(MaxChannels);
  localparam int unsigned CfgIdxW = 2;
  localparam int unsigned CfgDataW = 4;

  localparam logic [2:0] FmtFloat32 = 3'd0;
  localparam logic [2:0] FmtUnsigned8 = 3'd1;
  localparam logic [2:0] FmtSigned16 = 3'd2;
  localparam logic [2:0] FmtPacked24 = 3'd3;
  localparam logic [2:0] FmtSigned32 = 3'd4;
  localparam logic [2:0] FmtFix824 = 3'd5;

  localparam logic [CfgIdxW-1:0] RegSampleFormat = 2'd0;
  localparam logic [CfgIdxW-1:0] RegChannelCount = 2'd1;
  localparam logic [CfgIdxW-1:0] RegSelectedChannel = 2'd2;

  typedef struct packed {
    logic [2:0] sample_format;
    logic [3:0] channel_count;
    logic [2:0] selected_channel;
  } cfg_t;

  typedef struct packed {
    logic [31:0] raw_sample;
    logic        first_of_buffer;
  } in_item_t;

  typedef struct packed {
    logic signed [15:0] pcm_value;
  } out_item_t;
endpackage
`default_nettype wire

### design/pcpk_stream_if.sv
`default_nettype none
interface pcpk_stream_if #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

### design/pcpk_convert.sv
`default_nettype none
module pcpk_convert (
  input  wire logic [2:0]         fmt_i,
  input  wire logic [31:0]        raw_i,
  output logic signed [15:0]      pcm_o
);
  import pcpk_pkg::*;

  logic        neg;
  logic [7:0]  ex;
  logic [23:0] mant;
  logic [4:0]  r;
  logic [23:0] rmask;
  logic [23:0] rem;
  logic [23:0] half;
  logic [23:0] q;
  logic [23:0] qr;
  logic signed [15:0] fl;
  logic signed [23:0] fx;

  always_comb begin
    neg = raw_i[31];
    ex = raw_i[30:23];
    mant = {1'b1, raw_i[22:0]};
    // shift right by 135 - ex, valid in 1..24
    r = 5'(8'd135 - ex);
    rmask = (24'd1 << r) - 24'd1;
    rem = mant & rmask;
    half = 24'd1 << (r - 5'd1);
    q = mant >> r;
    qr = q;
    if (rem > half || (rem == half && q[0])) qr = q + 24'd1;
    if (ex >= 8'd135) qr = 24'h10000;
    else if (ex <= 8'd110) qr = '0;
    if (ex == 8'hFF) fl = neg ? -16'sd32768 : 16'sd32767;
    else if (ex == 8'h00) fl = '0;
    else if (neg) fl = (qr >= 24'd32768) ? -16'sd32768 : 16'(-qr);
    else fl = (qr >= 24'd32767) ? 16'sd32767 : 16'(qr);

    fx = raw_i[31:8];
    case (fmt_i)
      FmtFloat32: pcm_o = fl;
      FmtUnsigned8: pcm_o = {raw_i[7] ^ 1'b1, raw_i[6:0], 8'h00};
      FmtSigned16: pcm_o = raw_i[15:0];
      FmtPacked24: pcm_o = raw_i[23:8];
      FmtSigned32: pcm_o = raw_i[31:16];
      FmtFix824: begin
        if (fx > 24'sd32767) pcm_o = 16'sd32767;
        else if (fx < -24'sd32768) pcm_o = -16'sd32768;
        else pcm_o = fx[15:0];
      end
      default: pcm_o = '0;
    endcase
  end
endmodule
`default_nettype wire

### design/pcm_channel_pick_to_int16.sv
`default_nettype none
// channel | dir | payload
// in_s    | in  | raw_sample[31:0], first_of_buffer
// out_m   | out | pcm_value[15:0] signed
// cfg     | in  | cfg_we_i, cfg_idx_i[1:0], cfg_data_i[3:0]
// One item per cycle while out_m is not stalled. Stage 1 registers the
// accepted item together with its channel pick; stage 2 holds the converted
// result. Each stage takes new data when it is empty or its content moves on.
// Reset empties both stages, clears the channel position and loads the
// default configuration.
module pcm_channel_pick_to_int16 (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      cfg_we_i,
  input  wire logic [pcpk_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  wire logic [pcpk_pkg::CfgDataW-1:0] cfg_data_i,
  pcpk_stream_if.sink                    in_s,
  pcpk_stream_if.source                  out_m
);
  import pcpk_pkg::*;

  cfg_t cfg_q;
  logic [PosW-1:0] pos_q, pos_d;
  logic [3:0] count;
  logic keep;
  logic v1_q, v2_q;
  logic [31:0] raw1_q;
  logic [2:0] fmt1_q;
  logic signed [15:0] pcm;
  logic signed [15:0] pcm2_q;
  logic adv2, adv1, acc;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{sample_format: FmtSigned16, channel_count: 4'd2, selected_channel: 3'd0};
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        RegSampleFormat: cfg_q.sample_format <= cfg_data_i[2:0];
        RegChannelCount: cfg_q.channel_count <= cfg_data_i;
        RegSelectedChannel: cfg_q.selected_channel <= cfg_data_i[2:0];
        default: ;
      endcase
    end
  end

  assign adv2 = !v2_q || out_m.ready;
  assign adv1 = !v1_q || adv2;
  assign in_s.ready = adv1;
  assign acc = in_s.valid && adv1;

  always_comb begin
    logic [PosW-1:0] p;
    count = (cfg_q.channel_count > 4'(MaxChannels)) ? 4'(MaxChannels) : cfg_q.channel_count;
    p = in_s.data.first_of_buffer ? '0 : pos_q;
    keep = 1'b0;
    pos_d = '0;
    if (count != 4'd0) begin
      keep = (p == cfg_q.selected_channel) && ({1'b0, cfg_q.selected_channel} < count);
      pos_d = ({1'b0, p} + 4'd1 >= count) ? '0 : p + 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0;
      v1_q <= 1'b0;
      v2_q <= 1'b0;
    end else begin
      if (acc) pos_q <= pos_d;
      if (adv1) v1_q <= acc && keep;
      if (adv2) v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv1) begin
      raw1_q <= in_s.data.raw_sample;
      fmt1_q <= cfg_q.sample_format;
    end
    if (adv2) pcm2_q <= pcm;
  end

  pcpk_convert u_conv (
    .fmt_i (fmt1_q),
    .raw_i (raw1_q),
    .pcm_o (pcm)
  );

  assign out_m.valid = v2_q;
  assign out_m.data.pcm_value = pcm2_q;
endmodule
`default_nettype wire

### tb/tb_pcpk_scoreboard.sv
`timescale 1ns / 1ps
`default_nettype none
package tb_pcpk_scoreboard_pkg;
  import pcpk_pkg::*;

  class pcm_pick_scoreboard;
    logic [2:0] fmt;
    logic [3:0] n_chan;
    logic [2:0] pick;
    logic [2:0] chan_pos;
    logic signed [15:0] pcm_expected[$];
    int unsigned n_errors;

    function new();
      fmt = FmtSigned16;
      n_chan = 4'd2;
      pick = 3'd0;
      chan_pos = '0;
      n_errors = 0;
    endfunction

    function void write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] val);
      case (idx)
        RegSampleFormat: fmt = val[2:0];
        RegChannelCount: n_chan = val;
        RegSelectedChannel: pick = val[2:0];
        default: ;
      endcase
    endfunction

    function logic signed [15:0] float_to_pcm(logic [31:0] bits);
      logic [7:0] ex;
      logic [23:0] mant;
      int sh;
      int unsigned r;
      logic [31:0] q;
      logic [31:0] rem;
      logic [31:0] half;
      ex = bits[30:23];
      mant = {1'b1, bits[22:0]};
      if (ex == 8'hff) return bits[31] ? -16'sd32768 : 16'sd32767;
      if (ex == 8'h00) return '0;
      sh = int'(ex) - 135;
      if (sh >= 0) begin
        q = 32'h10000;
      end else if (sh <= -25) begin
        q = 0;
      end else begin
        r = -sh;
        rem = mant & ((32'd1 << r) - 1);
        half = 32'd1 << (r - 1);
        q = mant >> r;
        if (rem > half || (rem == half && q[0])) q++;
      end
      if (bits[31]) return (q >= 32768) ? -16'sd32768 : -$signed(q[15:0]);
      return (q >= 32767) ? 16'sd32767 : q[15:0];
    endfunction

    function logic signed [15:0] to_pcm(logic [31:0] raw);
      logic signed [31:0] t;
      case (fmt)
        FmtFloat32: return float_to_pcm(raw);
        FmtUnsigned8: return {raw[7:0] ^ 8'h80, 8'h00};
        FmtSigned16: return raw[15:0];
        FmtPacked24: return raw[23:8];
        FmtSigned32: return raw[31:16];
        FmtFix824: begin
          t = $signed(raw) >>> 8;
          if (t > 32767) return 16'sd32767;
          if (t < -32768) return -16'sd32768;
          return t[15:0];
        end
        default: return '0;
      endcase
    endfunction

    // returns 1 when the item produces a result
    function bit note_input(in_item_t it);
      int unsigned cnt;
      int unsigned p;
      bit hit;
      cnt = (n_chan > MaxChannels) ? MaxChannels : n_chan;
      if (it.first_of_buffer) chan_pos = '0;
      if (cnt == 0) begin
        chan_pos = '0;
        return 0;
      end
      p = chan_pos;
      hit = (p == pick) && (pick < cnt);
      if (hit) pcm_expected.push_back(to_pcm(it.raw_sample));
      chan_pos = (p + 1 >= cnt) ? '0 : p[2:0] + 3'd1;
      return hit;
    endfunction

    function void check_result(out_item_t res);
      logic signed [15:0] want;
      if (pcm_expected.size() == 0) begin
        report_bad($sformatf("unexpected pcm_value %0d", res.pcm_value));
        return;
      end
      want = pcm_expected.pop_front();
      if (res.pcm_value !== want)
        report_bad($sformatf("pcm_value %0d, want %0d", res.pcm_value, want));
    endfunction

    function void report_bad(string msg);
      n_errors++;
      if (n_errors <= 50) $display("mismatch: %s", msg);
    endfunction
  endclass
endpackage
`default_nettype wire

### tb/tb_pcm_channel_pick_to_int16.sv
`timescale 1ns / 1ps
`default_nettype none
module tb_pcm_channel_pick_to_int16;
  import pcpk_pkg::*;
  import tb_pcpk_scoreboard_pkg::*;

  localparam int unsigned IdleLimit = 2000;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [CfgIdxW-1:0] cfg_idx_i = '0;
  logic [CfgDataW-1:0] cfg_data_i = '0;

  pcpk_stream_if #(.T(in_item_t)) in_s ();
  pcpk_stream_if #(.T(out_item_t)) out_m ();

  pcm_pick_scoreboard sb;
  int unsigned idle_cycles;
  int unsigned n_results;
  bit stall_on;

  pcm_channel_pick_to_int16 i_dut (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .cfg_we_i(cfg_we_i),
    .cfg_idx_i(cfg_idx_i),
    .cfg_data_i(cfg_data_i),
    .in_s(in_s.sink),
    .out_m(out_m.source)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  initial begin
    in_s.valid = 1'b0;
    in_s.data = '0;
    out_m.ready = 1'b0;
    sb = new();
  end

  // receiver: alternates stall-free stretches with random back-pressure
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_m.valid && out_m.ready) begin
        sb.check_result(out_m.data);
        n_results++;
      end
      if ($urandom_range(0, 63) == 0) stall_on <= ~stall_on;
      out_m.ready <= stall_on ? ($urandom_range(0, 3) != 0) : 1'b1;
    end
  end

  always @(posedge clk_i) begin
    if ((in_s.valid && in_s.ready) || (out_m.valid && out_m.ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IdleLimit) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // leaves the write enable high; set_cfg drops it after the last write
  task automatic write_reg(logic [CfgIdxW-1:0] idx, logic [CfgDataW-1:0] val);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    @(posedge clk_i);
    sb.write_reg(idx, val);
  endtask

  task automatic set_cfg(logic [2:0] fmt, logic [3:0] cnt, logic [2:0] sel);
    write_reg(RegSampleFormat, {1'b0, fmt});
    write_reg(RegChannelCount, cnt);
    write_reg(RegSelectedChannel, {1'b0, sel});
    cfg_we_i <= 1'b0;
  endtask

  // holds valid until the item is taken; without keep_valid it then drops valid
  task automatic send_item(logic [31:0] raw, logic fob, bit keep_valid);
    in_item_t it;
    it.raw_sample = raw;
    it.first_of_buffer = fob;
    in_s.valid <= 1'b1;
    in_s.data <= it;
    do @(posedge clk_i); while (!in_s.ready);
    void'(sb.note_input(it));
    if (!keep_valid) begin
      in_s.valid <= 1'b0;
      @(posedge clk_i);
    end
  endtask

  task automatic drain();
    while (sb.pcm_expected.size() != 0) @(posedge clk_i);
    repeat (6) @(posedge clk_i);
  endtask

  function automatic logic [31:0] rand_raw(logic [2:0] fmt);
    case ($urandom_range(0, 7))
      0: return 32'h0;
      1: return 32'hffff_ffff;
      2: return 32'h8000_0000;
      3: return 32'h7fff_ffff;
      4: if (fmt == FmtFloat32)
           return {$urandom_range(0, 1) == 1, 8'($urandom_range(100, 145)), 23'($urandom)};
      default: ;
    endcase
    return $urandom;
  endfunction

  task automatic run_random(int unsigned n_items, logic [2:0] fmt);
    int unsigned left;
    int unsigned burst;
    left = n_items;
    while (left > 0) begin
      burst = $urandom_range(1, 16);
      if (burst > left) burst = left;
      for (int unsigned k = 0; k < burst; k++)
        send_item(rand_raw(fmt), $urandom_range(0, 15) == 0, k + 1 < burst);
      left -= burst;
      if ($urandom_range(0, 2) != 0) repeat ($urandom_range(1, 5)) @(posedge clk_i);
    end
  endtask

  initial begin
    logic [31:0] edge_raw[$];
    edge_raw = '{32'h0, 32'hffff_ffff, 32'h7fff_ffff, 32'h8000_0000, 32'h3f80_0000,
                 32'hbf80_0000, 32'h7f80_0000, 32'hff80_0000, 32'h7fc0_0000, 32'h3700_0000,
                 32'h3700_8000, 32'h3700_0100, 32'h0000_0080, 32'h0080_0000,
                 32'h5555_5555, 32'haaaa_aaaa, 32'h3f7f_ffff, 32'h0000_7f7f};
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    // defaults first: signed16, two channels, pick 0
    foreach (edge_raw[k]) send_item(edge_raw[k], k == 5, 1'b0);
    drain();
    // each format on a mono stream with edge values
    for (int f = 0; f < 8; f++) begin
      set_cfg(3'(f), 4'd1, 3'd0);
      foreach (edge_raw[k]) send_item(edge_raw[k], 1'b0, k + 1 < edge_raw.size());
      drain();
    end
    // pick out of range, zero channels, oversize count
    set_cfg(FmtSigned16, 4'd3, 3'd5);
    run_random(10, FmtSigned16);
    drain();
    set_cfg(FmtSigned16, 4'd0, 3'd0);
    run_random(10, FmtSigned16);
    drain();
    set_cfg(FmtSigned16, 4'd15, 3'd7);
    run_random(40, FmtSigned16);
    drain();
    // position beyond a shrunk count
    set_cfg(FmtSigned16, 4'd8, 3'd6);
    for (int k = 0; k < 6; k++) send_item($urandom, 1'b0, 1'b0);
    drain();
    set_cfg(FmtSigned16, 4'd3, 3'd6);
    run_random(6, FmtSigned16);
    drain();
    // random phases, mostly valid picks with few channels
    for (int ph = 0; ph < 24; ph++) begin
      logic [2:0] fmt;
      logic [3:0] cnt;
      fmt = (ph % 7 == 6) ? 3'($urandom_range(6, 7)) : 3'($urandom_range(0, 5));
      cnt = ($urandom_range(0, 7) == 0) ? 4'($urandom_range(0, 15)) : 4'($urandom_range(1, 3));
      set_cfg(fmt, cnt, (cnt > 0 && $urandom_range(0, 5) != 0) ?
              3'($urandom_range(0, (cnt > 8 ? 8 : cnt) - 1)) : 3'($urandom));
      run_random(15, fmt);
      drain();
    end
    if (sb.n_errors == 0 && sb.pcm_expected.size() == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end
endmodule
`default_nettype wire

### pcm_channel_pick_to_int16.f
design/pcpk_pkg.sv
design/pcpk_stream_if.sv
design/pcpk_convert.sv
design/pcm_channel_pick_to_int16.sv
tb/tb_pcpk_scoreboard.sv
tb/tb_pcm_channel_pick_to_int16.sv
